// ----- rtl/v2n_pkg.sv -----
`default_nettype none

package v2n_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_WIDTH     = UNIT_FRAC_BITS + 2;
  localparam int FINE_WIDTH     = COORD_WIDTH + UNIT_FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
  } vec_in_t;

  typedef struct packed {
    logic signed [UNIT_WIDTH-1:0] unit_x;
    logic signed [UNIT_WIDTH-1:0] unit_y;
    logic        [COORD_WIDTH-1:0] vec_length;
    logic                          fell_back;
  } vec_out_t;

endpackage

`default_nettype wire

// ----- rtl/v2n_sqrt.sv -----
`default_nettype none

module v2n_sqrt #(
  parameter int COORD_W = 16,
  parameter int FRAC_W  = 14,
  parameter int SIDE_W  = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [2*COORD_W-1:0]         in_sq,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_valid,
  output logic [COORD_W+FRAC_W-1:0]         out_root,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int W  = COORD_W + FRAC_W;
  localparam int RW = 2 * W;

  logic                 vld  [0:W];
  logic [W+1:0]         rem  [0:W];
  logic [W-1:0]         root [0:W];
  logic [2*COORD_W-1:0] sqv  [0:W];
  logic [SIDE_W-1:0]    sd   [0:W];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sqv[0]  = in_sq;
  assign sd[0]   = in_side;

  // One result bit per stage, two radicand bits brought down each time.
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [RW-1:0] rad;
    logic [W+3:0]  cur;
    logic [W+3:0]  trial;
    assign rad   = {sqv[i], {(2*FRAC_W){1'b0}}};
    assign cur   = {rem[i], rad[RW-1-2*i -: 2]};
    assign trial = cur - {2'b00, root[i], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!trial[W+3]) begin
        rem[i+1]  <= trial[W+1:0];
        root[i+1] <= {root[i][W-2:0], 1'b1};
      end else begin
        rem[i+1]  <= cur[W+1:0];
        root[i+1] <= {root[i][W-2:0], 1'b0};
      end
      sqv[i+1] <= sqv[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[W];
  assign out_root  = root[W];
  assign out_side  = sd[W];

endmodule

`default_nettype wire

// ----- rtl/v2n_div.sv -----
`default_nettype none

module v2n_div #(
  parameter int COORD_W = 16,
  parameter int FRAC_W  = 14,
  parameter int SIDE_W  = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [COORD_W-1:0]           in_mag_a,
  input  wire logic [COORD_W-1:0]           in_mag_b,
  input  wire logic [COORD_W+FRAC_W-1:0]    in_den,
  input  wire logic [SIDE_W-1:0]            in_side,
  output logic                              out_valid,
  output logic [FRAC_W:0]                   out_q_a,
  output logic [FRAC_W:0]                   out_q_b,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int W = COORD_W + FRAC_W;
  localparam int N = FRAC_W + 1;

  logic              vld [0:N];
  logic [W:0]        ra  [0:N];
  logic [W:0]        rb  [0:N];
  logic [FRAC_W:0]   qa  [0:N];
  logic [FRAC_W:0]   qb  [0:N];
  logic [W-1:0]      den [0:N];
  logic [SIDE_W-1:0] sd  [0:N];

  assign vld[0] = in_valid;
  assign ra[0]  = {2'b00, in_mag_a, {(FRAC_W-1){1'b0}}};
  assign rb[0]  = {2'b00, in_mag_b, {(FRAC_W-1){1'b0}}};
  assign qa[0]  = '0;
  assign qb[0]  = '0;
  assign den[0] = in_den;
  assign sd[0]  = in_side;

  // Restoring division, one quotient bit per stage for both lanes.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W+1:0] ta;
    logic [W+1:0] tb;
    logic         ga;
    logic         gb;
    logic [W+1:0] da;
    logic [W+1:0] db;
    assign ta = {ra[i], 1'b0};
    assign tb = {rb[i], 1'b0};
    assign ga = ta >= {2'b00, den[i]};
    assign gb = tb >= {2'b00, den[i]};
    assign da = ta - {2'b00, den[i]};
    assign db = tb - {2'b00, den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      ra[i+1]  <= ga ? da[W:0] : ta[W:0];
      rb[i+1]  <= gb ? db[W:0] : tb[W:0];
      qa[i+1]  <= {qa[i][FRAC_W-1:0], ga};
      qb[i+1]  <= {qb[i][FRAC_W-1:0], gb};
      den[i+1] <= den[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[N];
  assign out_q_a   = qa[N];
  assign out_q_b   = qb[N];
  assign out_side  = sd[N];

endmodule

`default_nettype wire

// ----- rtl/vector2_normalize.sv -----
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// The pipeline depth comes from the bit-per-stage square root and bit-per-stage divider pipelines.
// Synchronous reset clears all valid bits and sets min_length to 1.
`default_nettype none

module vector2_normalize (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire v2n_pkg::vec_in_t  vec_in,
  output logic                   done,
  output v2n_pkg::vec_out_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);
  import v2n_pkg::*;

  localparam int C  = COORD_WIDTH;
  localparam int F  = UNIT_FRAC_BITS;
  localparam int W  = FINE_WIDTH;
  localparam int S1 = 2*C + 3;
  localparam int S2 = C + 3 + 1;

  logic [15:0] min_length;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      min_length <= cfg_data;
    end
  end

  logic                 v0, v1, v2, v3;
  logic signed [C-1:0]  x0, y0;
  logic [C-1:0]         mx1, my1, mx2, my2, mx3, my3;
  logic                 nx1, ny1, yg1, nx2, ny2, yg2, nx3, ny3, yg3;
  logic [2*C-1:0]       sqx2, sqy2, sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x0   <= vec_in.vec_x;
    y0   <= vec_in.vec_y;
    nx1  <= x0[C-1];
    ny1  <= y0[C-1];
    mx1  <= x0[C-1] ? (~x0 + 1'b1) : x0;
    my1  <= y0[C-1] ? (~y0 + 1'b1) : y0;
    yg1  <= y0 > x0;
    sqx2 <= mx1 * mx1;
    sqy2 <= my1 * my1;
    mx2  <= mx1;
    my2  <= my1;
    nx2  <= nx1;
    ny2  <= ny1;
    yg2  <= yg1;
    sq3  <= sqx2 + sqy2;
    mx3  <= mx2;
    my3  <= my2;
    nx3  <= nx2;
    ny3  <= ny2;
    yg3  <= yg2;
  end

  logic          sv;
  logic [W-1:0]  root;
  logic [S1-1:0] sside;
  logic [C-1:0]  slen;
  logic          sfell;

  v2n_sqrt #(.COORD_W(C), .FRAC_W(F), .SIDE_W(S1)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_sq     (sq3),
    .in_side   ({mx3, my3, nx3, ny3, yg3}),
    .out_valid (sv),
    .out_root  (root),
    .out_side  (sside)
  );

  assign slen  = root[W-1:F];
  assign sfell = (slen < min_length) || (root == '0);

  logic          dv;
  logic [F:0]    qx, qy;
  logic [S2-1:0] dside;

  v2n_div #(.COORD_W(C), .FRAC_W(F), .SIDE_W(S2)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv),
    .in_mag_a  (sside[S1-1 -: C]),
    .in_mag_b  (sside[S1-1-C -: C]),
    .in_den    (root),
    .in_side   ({sside[2:0], sfell, slen}),
    .out_valid (dv),
    .out_q_a   (qx),
    .out_q_b   (qy),
    .out_side  (dside)
  );

  logic                    onx, ony, oyg, ofell;
  logic [C-1:0]            olen;
  logic [F:0]              cx, cy;
  logic [UNIT_WIDTH-1:0]   one;
  vec_out_t                res_next;

  assign {onx, ony, oyg, ofell, olen} = dside;
  assign one = UNIT_WIDTH'(1) << F;
  assign cx  = (qx > one[F:0]) ? one[F:0] : qx;
  assign cy  = (qy > one[F:0]) ? one[F:0] : qy;

  always_comb begin
    res_next.vec_length = olen;
    res_next.fell_back  = ofell;
    if (ofell) begin
      res_next.unit_x = oyg ? '0 : one;
      res_next.unit_y = oyg ? one : '0;
    end else begin
      res_next.unit_x = onx ? (~{1'b0, cx} + 1'b1) : {1'b0, cx};
      res_next.unit_y = ony ? (~{1'b0, cy} + 1'b1) : {1'b0, cy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

`default_nettype wire

// ----- tb/vector2_normalize_tb.sv -----
`default_nettype none

module vector2_normalize_tb;
  import v2n_pkg::*;

  localparam int LATENCY = COORD_WIDTH + 2*UNIT_FRAC_BITS + 5;
  localparam logic [UNIT_WIDTH-1:0] UNIT_ONE = UNIT_WIDTH'(1) << UNIT_FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  vec_in_t vec_in = '0;
  logic done;
  vec_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  logic [15:0] min_len_model;
  vec_out_t expected_q[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int fallbacks_seen = 0;
  int idle_pct = 0;

  vector2_normalize DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .vec_in(vec_in),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [UNIT_WIDTH-1:0] scale_comp(input logic [63:0] mag,
                                                      input logic neg,
                                                      input logic [63:0] fine);
    logic [63:0] q;
    q = (mag << (2*UNIT_FRAC_BITS)) / fine;
    if (q > UNIT_ONE) q = UNIT_ONE;
    if (neg) q = -q;
    return q[UNIT_WIDTH-1:0];
  endfunction

  function automatic vec_out_t normalize(input vec_in_t v);
    vec_out_t r;
    logic [63:0] mx, my, sq, len, fine;
    logic nx, ny;
    nx = v.vec_x[COORD_WIDTH-1];
    ny = v.vec_y[COORD_WIDTH-1];
    mx = nx ? 64'(-$signed(64'(v.vec_x))) : 64'(v.vec_x);
    my = ny ? 64'(-$signed(64'(v.vec_y))) : 64'(v.vec_y);
    sq = mx*mx + my*my;
    len = isqrt(sq);
    fine = isqrt(sq << (2*UNIT_FRAC_BITS));
    r.vec_length = len[COORD_WIDTH-1:0];
    if (len < min_len_model || fine == 0) begin
      r.fell_back = 1'b1;
      if (v.vec_y > v.vec_x) begin
        r.unit_x = '0;
        r.unit_y = UNIT_ONE;
      end else begin
        r.unit_x = UNIT_ONE;
        r.unit_y = '0;
      end
    end else begin
      r.fell_back = 1'b0;
      r.unit_x = scale_comp(mx, nx, fine);
      r.unit_y = scale_comp(my, ny, fine);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    vec_out_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (result.fell_back) fallbacks_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", result);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result.unit_x !== exp_r.unit_x) begin
          $error("unit_x expected %h actual %h", exp_r.unit_x, result.unit_x);
          errors++;
        end
        if (result.unit_y !== exp_r.unit_y) begin
          $error("unit_y expected %h actual %h", exp_r.unit_y, result.unit_y);
          errors++;
        end
        if (result.vec_length !== exp_r.vec_length) begin
          $error("vec_length expected %h actual %h", exp_r.vec_length, result.vec_length);
          errors++;
        end
        if (result.fell_back !== exp_r.fell_back) begin
          $error("fell_back expected %b actual %b", exp_r.fell_back, result.fell_back);
          errors++;
        end
      end
    end
  end

  task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y);
    vec_in_t v;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    v.vec_x = x;
    v.vec_y = y;
    start <= 1'b1;
    vec_in <= v;
    do @(posedge clk); while (busy);
    expected_q.push_back(normalize(v));
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_len_model = val;
  endtask

  task automatic test_directed();
    send_vector(16'sh0000, 16'sh0000);
    send_vector(16'sh7FFF, 16'sh7FFF);
    send_vector(-16'sh8000, -16'sh8000);
    send_vector(-16'sh8000, 16'sh7FFF);
    send_vector(16'sh7FFF, -16'sh8000);
    send_vector(16'sh0100, 16'sh0000);
    send_vector(16'sh0000, 16'sh0100);
    send_vector(-16'sh0100, 16'sh0000);
    send_vector(16'sh0000, -16'sh0100);
    send_vector(16'sh0001, 16'sh0000);
    send_vector(16'sh0000, 16'sh0001);
    send_vector(-16'sh0001, -16'sh0001);
    send_vector(16'sh0300, 16'sh0400);
    send_vector(16'sh5555, -16'sh2AAA);
    send_vector(16'sh7FFF, 16'sh0000);
    send_vector(16'sh0000, -16'sh8000);
  endtask

  task automatic test_thresholds();
    write_min_length(16'd0);
    send_vector(16'sh0000, 16'sh0000);
    send_vector(16'sh0001, 16'sh0000);
    send_vector(-16'sh0001, 16'sh0000);
    write_min_length(16'hFFFF);
    send_vector(16'sh7FFF, 16'sh7FFF);
    send_vector(-16'sh1234, 16'sh4321);
    send_vector(16'sh4321, -16'sh1234);
    write_min_length(16'h0500);
    send_vector(16'sh0300, 16'sh0400);
    send_vector(16'sh0300, 16'sh03FF);
  endtask

  task automatic test_random(input int n, input int pct);
    logic signed [15:0] x, y;
    int shift;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      x = 16'($urandom);
      y = 16'($urandom);
      if ($urandom_range(3) == 0) begin
        shift = $urandom_range(15);
        x = x >>> shift;
        y = y >>> shift;
      end
      send_vector(x, y);
    end
    idle_pct = 0;
  endtask

  initial begin
    min_len_model = 16'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    write_min_length(16'h0200);
    test_random(350, 38);
    drain();
    write_min_length(16'h0010);
    test_random(350, 64);
    write_min_length(16'd1);
    test_random(350, 0);
    drain();
    $display("Sent %0d vectors over several thresholds; %0d results checked, %0d fell back.",
             words_sent, results_seen, fallbacks_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
